// ===== rtl/plc_pkg.sv =====
// Shared constants, codes and types for the piecewise linear curve block.
package plc_pkg;

    // Default sizing
    localparam int MAX_POINTS_DEF = 8;
    localparam int FRAC_BITS_DEF  = 16;

    // Fixed field widths
    localparam int VAL_W     = 32;
    localparam int PIDX_W    = 3;
    localparam int COUNT_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int ENTRY_W   = 2 * VAL_W;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [PIDX_W-1:0]       t_pidx;
    typedef logic [CFG_IDX_W-1:0]    t_cfg_idx;

    // Item actions
    localparam logic ACT_EVAL  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Configuration register indexes
    localparam t_cfg_idx CFG_POINT_COUNT    = 2'd0;
    localparam t_cfg_idx CFG_DEFAULT_OUTPUT = 2'd1;

endpackage

// ===== rtl/plc_if.sv =====
// Channel interfaces: input items, result items and configuration writes.
interface plc_in_if import plc_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  action;
    t_pidx point_index;
    t_val  point_x;
    t_val  point_y;
    t_val  query_x;

    modport source (output valid, action, point_index, point_x, point_y, query_x,
                    input ready);
    modport sink   (input valid, action, point_index, point_x, point_y, query_x,
                    output ready);
endinterface

interface plc_out_if import plc_pkg::*; ();
    logic valid;
    logic ready;
    t_val curve_value;

    modport source (output valid, curve_value, input ready);
    modport sink   (input valid, curve_value, output ready);
endinterface

interface plc_cfg_if import plc_pkg::*; ();
    logic             valid;
    logic             ready;
    t_cfg_idx         index;
    logic [VAL_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/plc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module plc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/plc_div.sv =====
// Restoring divider: one quotient bit per cycle for the segment fraction.
module plc_div #(
    parameter int QUO_W = 16,
    parameter int OP_W  = 33
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [OP_W-1:0]  i_num,
    input  logic [OP_W-1:0]  i_den,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic             r_busy, n_busy;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [OP_W-1:0]  r_rem, n_rem;
    logic [OP_W-1:0]  r_den;
    logic [QUO_W-1:0] r_quo, n_quo;
    logic             r_done, n_done;
    logic [OP_W:0]    shifted;
    logic [OP_W:0]    diff;

    // Shift the partial remainder and trial-subtract the divisor
    assign shifted = {r_rem, 1'b0};
    assign diff    = shifted - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(QUO_W);
            n_rem  = i_num;
        end else if (r_busy) begin
            if (!diff[OP_W]) begin
                n_rem = diff[OP_W-1:0];
                n_quo = {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[OP_W-1:0];
                n_quo = {r_quo[QUO_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/piecewise_linear_curve.sv =====
// Piecewise linear curve: breakpoint table, scan sequencer, divider and interpolation.
// Writes land in the table when taken. An evaluate with no points in use gives the default
// output; else the scan reads breakpoints in order (up to MAX_POINTS) and gives a breakpoint
// output or runs the divider (FRAC_BITS quotient bits), the multiply and saturating add.
// Throughput: one item at a time; after an evaluate ready is low until its result is taken.
// Reset: synchronous active-low clears the sequencer and config registers, not the table.
module piecewise_linear_curve import plc_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    plc_in_if.sink    i_pt,
    plc_out_if.source o_res,
    plc_cfg_if.sink   i_cfg
);

    // Table address and point count widths
    localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW     = $clog2(MAX_POINTS + 1);
    localparam int CW     = 8;
    // Difference, product and sum widths
    localparam int DIF_W  = VAL_W + 1;
    localparam int PROD_W = DIF_W + FRAC_BITS + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'($signed(32'h7FFF_FFFF));
    localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'($signed(32'h8000_0000));

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]               r_state, n_state;
    logic [AW-1:0]            r_idx, n_idx;
    logic [NW-1:0]            r_n, n_n;
    t_val                     r_q, n_q;
    t_val                     r_px, n_px;
    t_val                     r_py, n_py;
    logic signed [DIF_W-1:0]  r_dy, n_dy;
    logic signed [PROD_W-1:0] r_prod;
    t_val                     r_result, n_result;

    logic [COUNT_W-1:0]       r_point_count;
    t_val                     r_default_output;

    logic                     in_acc;
    logic                     wr_en;
    logic [ENTRY_W-1:0]       rd_data;
    t_val                     ent_x, ent_y;
    logic signed [DIF_W-1:0]  dx, num, dy;
    logic                     div_start, div_done;
    logic [FRAC_BITS-1:0]     div_quo;
    logic signed [PROD_W-1:0] prod_shift;
    logic signed [SUM_W-1:0]  sum;
    logic [NW-1:0]            eff_n;
    logic                     last_entry;

    // Configuration: always ready, unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count    <= '0;
            r_default_output <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_POINT_COUNT:    r_point_count    <= i_cfg.data[COUNT_W-1:0];
                CFG_DEFAULT_OUTPUT: r_default_output <= $signed(i_cfg.data);
                default: ;
            endcase
        end
    end

    // Input handshake: one item in flight at a time
    assign i_pt.ready = (r_state == S_IDLE);
    assign in_acc     = i_pt.valid && i_pt.ready;

    // Writes land in the table in the cycle of their transaction; out-of-range entries drop
    assign wr_en = in_acc && (i_pt.action == ACT_WRITE) && (32'(i_pt.point_index) < MAX_POINTS);

    plc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_pt.point_index)),
        .i_wdata ({i_pt.point_y, i_pt.point_x}),
        .i_raddr (n_idx),
        .o_rdata (rd_data)
    );

    assign ent_x = $signed(rd_data[VAL_W-1:0]);
    assign ent_y = $signed(rd_data[ENTRY_W-1:VAL_W]);

    // Segment width, offset into the segment and output rise, all one bit wider
    assign dx = $signed({ent_x[VAL_W-1], ent_x}) - $signed({r_px[VAL_W-1], r_px});
    assign num = $signed({r_q[VAL_W-1], r_q}) - $signed({r_px[VAL_W-1], r_px});
    assign dy = $signed({ent_y[VAL_W-1], ent_y}) - $signed({r_py[VAL_W-1], r_py});

    // Clamp the point count to the table depth
    assign eff_n = (32'(r_point_count) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(r_point_count);

    assign last_entry = (CW'(r_idx) + CW'(1)) == CW'(r_n);

    plc_div #(
        .QUO_W (FRAC_BITS),
        .OP_W  (DIF_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num[DIF_W-1] ? '0 : num),
        .i_den   (dx),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Floor division by 2^FRAC_BITS is an arithmetic shift; add the base and saturate
    assign prod_shift = r_prod >>> FRAC_BITS;
    assign sum = SUM_W'(r_py) + SUM_W'(prod_shift);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_n       = r_n;
        n_q       = r_q;
        n_px      = r_px;
        n_py      = r_py;
        n_dy      = r_dy;
        n_result  = r_result;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (in_acc && (i_pt.action == ACT_EVAL)) begin
                    n_q = i_pt.query_x;
                    n_n = eff_n;
                    if (eff_n == '0) begin
                        n_result = r_default_output;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx == '0) begin
                    // At or below the first point, or only one point: give its output
                    if (r_q <= ent_x || r_n == NW'(1)) begin
                        n_result = ent_y;
                        n_state  = S_OUT;
                    end else begin
                        n_px  = ent_x;
                        n_py  = ent_y;
                        n_idx = r_idx + 1'b1;
                    end
                end else if (ent_x > r_q) begin
                    // First point above the query closes the segment
                    if (dx <= 0) begin
                        n_result = r_py;
                        n_state  = S_OUT;
                    end else begin
                        div_start = 1'b1;
                        n_dy      = dy;
                        n_state   = S_DIV;
                    end
                end else if (last_entry) begin
                    // Past the last point in use
                    n_result = ent_y;
                    n_state  = S_OUT;
                end else begin
                    n_px  = ent_x;
                    n_py  = ent_y;
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (sum > SAT_MAX) begin
                    n_result = t_val'(32'h7FFF_FFFF);
                end else if (sum < SAT_MIN) begin
                    n_result = t_val'(32'h8000_0000);
                end else begin
                    n_result = sum[VAL_W-1:0];
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
        r_n      <= n_n;
        r_q      <= n_q;
        r_px     <= n_px;
        r_py     <= n_py;
        r_dy     <= n_dy;
        r_result <= n_result;
        // Step times fraction, fraction held unsigned; full product width
        if (r_state == S_MUL) begin
            r_prod <= r_dy * $signed({1'b0, div_quo});
        end
    end

    // Result channel: hold the value until the transaction completes
    assign o_res.valid       = (r_state == S_OUT);
    assign o_res.curve_value = r_result;

endmodule

// ===== tb/piecewise_linear_curve_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the piecewise linear curve: directed rows, then random phases.
module piecewise_linear_curve_test;
    import plc_pkg::*;

    // Spare configuration slots: writes there must leave both registers alone
    localparam t_cfg_idx CFG_SPARE_A = 2'd2;
    localparam t_cfg_idx CFG_SPARE_B = 2'd3;

    localparam t_val VAL_MIN   = 32'sh8000_0000;
    localparam t_val VAL_MAX   = 32'sh7FFF_FFFF;
    localparam int   SETTLE    = 40;     // cycles allowed after the last result
    localparam int   HOLD_AT   = 600;    // transactions taken before the long stall
    localparam int   HOLD_LEN  = 500;    // cycles of the long stall
    localparam int   PHASES    = 12;
    localparam int   PHASE_LEN = 150;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind kind;
        logic      act;
        t_pidx     idx;
        t_cfg_idx  sel;
        t_val      x;      // breakpoint x, or register data on a configuration row
        t_val      y;
        t_val      q;
        bit        known;  // curve value typed into the row
        t_val      want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    plc_in_if  pt_ch ();
    plc_out_if res_ch ();
    plc_cfg_if cfg_ch ();

    piecewise_linear_curve dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Mirror of the block: breakpoint table and both registers
    t_val        pt_x [MAX_POINTS_DEF];
    t_val        pt_y [MAX_POINTS_DEF];
    logic [3:0]  pred_count   = '0;
    t_val        pred_default = '0;

    t_val        pending_curve [$];
    t_stim_row   directed_rows [$];

    // Row being offered: carries the typed-in curve value to the monitor
    bit          cur_known;
    t_val        cur_want;

    int          fault_count  = 0;
    int          items_taken  = 0;
    int          burst_left   = 0;
    bit          tx_gaps      = 1'b1;
    bit          rx_stalls    = 1'b1;
    int          hold_left    = 0;
    bit          held         = 1'b0;
    int          rx_left      = 0;
    bit          rx_open      = 1'b0;

    // 4 ns clock: low half then high half
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Generous ceiling on the whole run
    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // Curve value at q for the current table and registers
    function automatic t_val curve_at(t_val q);
        int          n;
        int          i;
        longint      x0;
        longint      y0;
        longint      dx;
        longint      num;
        longint      step;
        longint      sum;
        logic [63:0] frac;
        n = (pred_count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : int'(pred_count);
        if (n == 0)
            return pred_default;
        if (q <= pt_x[0])
            return pt_y[0];
        for (i = 1; i < n; i++) begin
            if (pt_x[i] > q) begin
                x0 = pt_x[i-1];
                y0 = pt_y[i-1];
                dx = longint'(pt_x[i]) - x0;
                if (dx <= 0)
                    return pt_y[i-1];
                num = longint'(q) - x0;
                if (num < 0)
                    num = 0;
                frac = ($unsigned(num) << FRAC_BITS_DEF) / $unsigned(dx);
                // arithmetic shift rounds toward minus infinity
                step = ((longint'(pt_y[i]) - y0) * $signed(frac)) >>> FRAC_BITS_DEF;
                sum  = y0 + step;
                if (sum > longint'(VAL_MAX))
                    return VAL_MAX;
                if (sum < longint'(VAL_MIN))
                    return VAL_MIN;
                return t_val'(sum);
            end
        end
        return pt_y[n-1];
    endfunction

    // Output level: full range, small around zero, or an extreme now and then
    function automatic t_val random_level(int mode);
        case (mode)
            1:       return t_val'($urandom_range(0, 'h3FFFF)) - 32'sh0002_0000;
            2:       return ($urandom_range(0, 3) == 0) ? VAL_MIN :
                            ($urandom_range(0, 2) == 0) ? VAL_MAX : t_val'($urandom);
            default: return t_val'($urandom);
        endcase
    endfunction

    task automatic plan_item(logic act, t_pidx idx, t_val x, t_val y, t_val q,
                             bit known, t_val want);
        t_stim_row r;
        r.kind  = ROW_ITEM;
        r.act   = act;
        r.idx   = idx;
        r.sel   = CFG_POINT_COUNT;
        r.x     = x;
        r.y     = y;
        r.q     = q;
        r.known = known;
        r.want  = want;
        directed_rows.push_back(r);
    endtask

    task automatic plan_cfg(t_cfg_idx sel, t_val data);
        t_stim_row r;
        r.kind  = ROW_CFG;
        r.act   = ACT_EVAL;
        r.idx   = '0;
        r.sel   = sel;
        r.x     = data;
        r.y     = '0;
        r.q     = '0;
        r.known = 1'b0;
        r.want  = '0;
        directed_rows.push_back(r);
    endtask

    // Offer one item; call at a falling edge, return at the edge that takes it
    task automatic offer_item(logic act, t_pidx idx, t_val x, t_val y, t_val q,
                              bit known, t_val want);
        if (tx_gaps && burst_left == 0) begin
            pt_ch.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left != 0)
            burst_left--;
        pt_ch.action      = act;
        pt_ch.point_index = idx;
        pt_ch.point_x     = x;
        pt_ch.point_y     = y;
        pt_ch.query_x     = q;
        cur_known         = known;
        cur_want          = want;
        pt_ch.valid       = 1'b1;
        do @(posedge i_clk); while (!pt_ch.ready);
    endtask

    // Drop valid, wait for every outstanding curve value, then let the block go quiet
    task automatic settle();
        @(negedge i_clk);
        pt_ch.valid = 1'b0;
        while (pending_curve.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Register write; only ever issued while the block is idle
    task automatic cfg_write(t_cfg_idx sel, logic [VAL_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.index = sel;
        cfg_ch.data  = data;
        cfg_ch.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (sel == CFG_POINT_COUNT)
            pred_count = data[COUNT_W-1:0];
        else if (sel == CFG_DEFAULT_OUTPUT)
            pred_default = t_val'(data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Input monitor: update the table on writes, queue the curve value on evaluates
    always @(posedge i_clk) begin
        if (i_rst_n && pt_ch.valid && pt_ch.ready) begin
            items_taken++;
            if (pt_ch.action == ACT_WRITE) begin
                pt_x[pt_ch.point_index] = pt_ch.point_x;
                pt_y[pt_ch.point_index] = pt_ch.point_y;
            end else begin
                pending_curve.push_back(cur_known ? cur_want : curve_at(pt_ch.query_x));
            end
        end
    end

    // Result monitor: compare each transaction with the oldest queued value
    always @(posedge i_clk) begin : check_results
        t_val want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_curve.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected curve_value %0d (0x%08h) at %0t",
                             res_ch.curve_value, res_ch.curve_value, $realtime);
            end else begin
                want = pending_curve.pop_front();
                if (res_ch.curve_value !== want) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("curve_value mismatch at %0t: expected %0d (0x%08h),",
                                 $realtime, want, want, " got %0d (0x%08h)",
                                 res_ch.curve_value, res_ch.curve_value);
                end
            end
        end
    end

    // Receiver: random open/stall runs or always ready; one long hold-off after HOLD_AT items
    always @(negedge i_clk) begin : receiver
        logic rdy;
        if (hold_left != 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (!held && items_taken >= HOLD_AT) begin
            held      = 1'b1;
            hold_left = HOLD_LEN - 1;
            rdy       = 1'b0;
        end else if (!rx_stalls) begin
            rdy = 1'b1;
        end else begin
            if (rx_left == 0) begin
                rx_open = !rx_open;
                rx_left = rx_open ? $urandom_range(1, 12) : $urandom_range(1, 6);
            end
            rx_left--;
            rdy = rx_open;
        end
        res_ch.ready = rdy;
    end

    initial begin
        int          ph;
        int          k;
        int          e;
        int          n;
        int          s;
        int          pick;
        int          phase_count [PHASES];
        bit          sorted;
        int unsigned maxstep;
        longint      walk;
        longint      lo;
        longint      hi;
        logic [63:0] r64;
        logic [31:0] data;
        t_val        x;
        t_val        y;
        t_val        q;

        phase_count = '{8, 3, 15, 0, 1, 2, 5, 8, 12, 7, 4, 6};

        // Drive every input to a known level before reset
        i_rst_n           = 1'b0;
        pt_ch.valid       = 1'b0;
        pt_ch.action      = ACT_EVAL;
        pt_ch.point_index = '0;
        pt_ch.point_x     = '0;
        pt_ch.point_y     = '0;
        pt_ch.query_x     = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_POINT_COUNT;
        cfg_ch.data       = '0;
        res_ch.ready      = 1'b0;
        cur_known         = 1'b0;
        cur_want          = '0;
        for (e = 0; e < MAX_POINTS_DEF; e++) begin
            pt_x[e] = '0;
            pt_y[e] = '0;
        end

        // Directed rows. No breakpoint is read before all eight are written.
        plan_item(ACT_EVAL, '0, 0, 0, 0, 1'b1, 0);                  // reset: default is zero
        plan_cfg(CFG_DEFAULT_OUTPUT, VAL_MIN);
        plan_item(ACT_EVAL, '0, 0, 0, VAL_MAX, 1'b1, VAL_MIN);
        plan_cfg(CFG_DEFAULT_OUTPUT, VAL_MAX);
        plan_item(ACT_EVAL, '0, 0, 0, VAL_MIN, 1'b1, VAL_MAX);
        // Table: extremes at both ends, a duplicate x, one entry out of order
        plan_item(ACT_WRITE, 3'd0, VAL_MIN,         VAL_MIN,         0, 1'b0, 0);
        plan_item(ACT_WRITE, 3'd1, -32'sh0002_0000, 32'sh0003_0000,  0, 1'b0, 0);
        plan_item(ACT_WRITE, 3'd2, 32'sh0000_0000,  -32'sh0001_0000, 0, 1'b0, 0);
        plan_item(ACT_WRITE, 3'd3, 32'sh0001_8000,  VAL_MAX,         0, 1'b0, 0);
        plan_item(ACT_WRITE, 3'd4, 32'sh0001_8000,  32'sh0007_0000,  0, 1'b0, 0);
        plan_item(ACT_WRITE, 3'd5, 32'sh4000_0000,  VAL_MIN,         0, 1'b0, 0);
        plan_item(ACT_WRITE, 3'd6, 32'sh3000_0000,  32'sh0000_1234,  0, 1'b0, 0);
        plan_item(ACT_WRITE, 3'd7, VAL_MAX,         VAL_MAX,         0, 1'b0, 0);
        plan_item(ACT_EVAL, '0, 0, 0, 0, 1'b1, VAL_MAX);            // no points in use
        plan_cfg(CFG_POINT_COUNT, 1);
        plan_item(ACT_EVAL, '0, 0, 0, VAL_MAX, 1'b1, VAL_MIN);      // beyond a single point
        plan_item(ACT_EVAL, '0, 0, 0, VAL_MIN, 1'b1, VAL_MIN);      // at the first point
        plan_cfg(CFG_POINT_COUNT, 8);
        plan_item(ACT_EVAL, '0, 0, 0, VAL_MIN, 1'b1, VAL_MIN);
        plan_item(ACT_EVAL, '0, 0, 0, VAL_MAX, 1'b1, VAL_MAX);      // beyond the last point
        plan_item(ACT_EVAL, '0, 0, 0, -32'sh0001_0000, 1'b0, 0);
        plan_item(ACT_EVAL, '0, 0, 0, 32'sh0000_8000, 1'b0, 0);
        plan_item(ACT_EVAL, '0, 0, 0, 32'sh3800_0000, 1'b0, 0);
        plan_item(ACT_EVAL, '0, 0, 0, -32'sh4000_0000, 1'b0, 0);    // widest segment
        plan_cfg(CFG_POINT_COUNT, 15);                               // clamps to the table size
        plan_item(ACT_EVAL, '0, 0, 0, VAL_MAX, 1'b1, VAL_MAX);
        plan_item(ACT_EVAL, '0, 0, 0, 32'sh7FFF_FFFE, 1'b0, 0);
        plan_cfg(CFG_SPARE_A, 0);                                    // unknown slots: no effect
        plan_cfg(CFG_SPARE_B, 32'hFFFF_FFFF);
        plan_item(ACT_EVAL, '0, 0, 0, VAL_MIN, 1'b1, VAL_MIN);
        plan_cfg(CFG_POINT_COUNT, 0);
        plan_item(ACT_EVAL, '0, 0, 0, 32'sh0000_1000, 1'b1, VAL_MAX);

        // Hold reset, then release it on a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table
        for (k = 0; k < directed_rows.size(); k++) begin
            if (directed_rows[k].kind == ROW_CFG) begin
                settle();
                cfg_write(directed_rows[k].sel, directed_rows[k].x);
            end else begin
                @(negedge i_clk);
                offer_item(directed_rows[k].act, directed_rows[k].idx, directed_rows[k].x,
                           directed_rows[k].y, directed_rows[k].q,
                           directed_rows[k].known, directed_rows[k].want);
            end
        end

        // Random phases: each rebuilds the table, then mixes evaluates with rewrites
        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            tx_gaps   = (ph % 4 == 0) || (ph % 4 == 2);
            rx_stalls = (ph % 4 == 0) || (ph % 4 == 3);
            sorted    = (ph % 4 != 1);

            // Count with stray upper bits in alternate phases
            data = (ph % 2) ? (($urandom & 32'hFFFF_FFF0) | 32'(phase_count[ph]))
                            : 32'(phase_count[ph]);
            cfg_write(CFG_POINT_COUNT, data);
            case (ph % 3)
                0:       cfg_write(CFG_DEFAULT_OUTPUT, VAL_MIN);
                1:       cfg_write(CFG_DEFAULT_OUTPUT, VAL_MAX);
                default: cfg_write(CFG_DEFAULT_OUTPUT, $urandom);
            endcase
            if (ph % 3 == 1)
                cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);

            // Fresh table: ascending x at one of three spacings, or scattered
            case ($urandom_range(0, 2))
                0:       maxstep = 32'h0000_FFFF;
                1:       maxstep = 32'h00FF_FFFF;
                default: maxstep = 32'h1FFF_FFFF;
            endcase
            walk = (maxstep > 32'h00FF_FFFF) ? longint'(VAL_MIN) + $urandom_range(0, 'h0FFF_FFFF)
                                             : longint'(t_val'($urandom));
            for (e = 0; e < MAX_POINTS_DEF; e++) begin
                @(negedge i_clk);
                x = sorted ? t_val'(walk) : t_val'($urandom);
                offer_item(ACT_WRITE, t_pidx'(e), x, random_level(ph % 3), $urandom, 1'b0, '0);
                if ($urandom_range(0, 9) != 0)
                    walk += $urandom_range(0, maxstep);
                if (walk > longint'(VAL_MAX))
                    walk = VAL_MAX;
            end

            for (k = 0; k < PHASE_LEN; k++) begin
                @(negedge i_clk);
                n = (pred_count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : int'(pred_count);
                r64 = {$urandom, $urandom};
                if ($urandom_range(0, 99) < 15) begin
                    // Rewrite an entry, mostly keeping the x order intact
                    e  = $urandom_range(0, MAX_POINTS_DEF - 1);
                    lo = (e == 0) ? longint'(VAL_MIN) : longint'(pt_x[e-1]);
                    hi = (e == MAX_POINTS_DEF - 1) ? longint'(VAL_MAX) : longint'(pt_x[e+1]);
                    if (sorted && hi >= lo && $urandom_range(0, 9) < 7)
                        x = t_val'(lo + $signed(r64 % $unsigned(hi - lo + 1)));
                    else
                        x = t_val'($urandom);
                    offer_item(ACT_WRITE, t_pidx'(e), x, random_level(ph % 3), $urandom,
                               1'b0, '0);
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50 && n >= 2) begin
                        // Inside a segment, where the interpolation happens
                        s  = $urandom_range(0, n - 2);
                        lo = pt_x[s];
                        hi = pt_x[s+1];
                        q  = (hi > lo) ? t_val'(lo + $signed(r64 % $unsigned(hi - lo)))
                                       : t_val'(lo);
                    end else if (pick < 65 && n >= 1) begin
                        // On a breakpoint or one step either side
                        q = pt_x[$urandom_range(0, n - 1)] + t_val'($urandom_range(0, 2)) - 1;
                    end else if (pick < 75) begin
                        case ($urandom_range(0, 3))
                            0:       q = VAL_MIN;
                            1:       q = VAL_MAX;
                            2:       q = VAL_MIN + 1;
                            default: q = VAL_MAX - 1;
                        endcase
                    end else begin
                        q = t_val'($urandom);
                    end
                    offer_item(ACT_EVAL, t_pidx'($urandom), $urandom, $urandom, q, 1'b0, '0);
                end
            end
        end

        // Drain and give any stray result time to show up
        settle();
        if (fault_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/plc_pkg.sv
rtl/plc_if.sv
rtl/plc_ram.sv
rtl/plc_div.sv
rtl/piecewise_linear_curve.sv
tb/piecewise_linear_curve_test.sv
